// ----- hdl/sm4c_pkg.sv -----
// Shared types, constants and cipher tables for the SM4 CBC encryptor.
`timescale 1ns / 1ps
package sm4c_pkg;

  localparam int BLOCK_W    = 128;
  localparam int HALF_W     = 64;
  localparam int WORD_W     = 32;
  localparam int VB_W       = 5;
  localparam int NUM_ROUNDS = 32;
  localparam int RIDX_W     = $clog2(NUM_ROUNDS);
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 64;
  localparam int IN_DATA_W  = 136;
  localparam int OUT_DATA_W = 128;
  localparam int NUM_BYTES  = 16;

  localparam logic [VB_W-1:0]       FULL_BYTES = VB_W'(NUM_BYTES);
  localparam logic [7:0]            PAD_BYTE   = 8'h20;
  localparam logic [RIDX_W-1:0]     ROUND_LAST = RIDX_W'(NUM_ROUNDS - 1);

  localparam logic [CFG_ADDR_W-1:0] REG_KEY_HIGH = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_KEY_LOW  = 1'b1;

  localparam logic [WORD_W-1:0] FK0 = 32'ha3b1bac6;
  localparam logic [WORD_W-1:0] FK1 = 32'h56aa3350;
  localparam logic [WORD_W-1:0] FK2 = 32'h677d9197;
  localparam logic [WORD_W-1:0] FK3 = 32'hb27022dc;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KLOAD,
    ST_KEY,
    ST_ROUND,
    ST_DONE
  } sm4c_state_t;

  typedef struct packed {
    logic                  load_key;
    logic                  load_data;
    logic                  round_en;
    logic                  key_mode;
    logic                  finish;
    logic [RIDX_W-1:0]     round_idx;
  } sm4c_cmd_t;

  typedef struct packed {
    logic out_busy;
  } sm4c_status_t;

  localparam logic [7:0] SBOX_TABLE [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  localparam logic [WORD_W-1:0] CK_TABLE [NUM_ROUNDS] = '{
    32'h00070e15,32'h1c232a31,32'h383f464d,32'h545b6269,
    32'h70777e85,32'h8c939aa1,32'ha8afb6bd,32'hc4cbd2d9,
    32'he0e7eef5,32'hfc030a11,32'h181f262d,32'h343b4249,
    32'h50575e65,32'h6c737a81,32'h888f969d,32'ha4abb2b9,
    32'hc0c7ced5,32'hdce3eaf1,32'hf8ff060d,32'h141b2229,
    32'h30373e45,32'h4c535a61,32'h686f767d,32'h848b9299,
    32'ha0a7aeb5,32'hbcc3cad1,32'hd8dfe6ed,32'hf4fb0209,
    32'h10171e25,32'h2c333a41,32'h484f565d,32'h646b7279
  };

  // Byte-wise S-box substitution of one word.
  function automatic logic [WORD_W-1:0] sub_word(input logic [WORD_W-1:0] x);
    sub_word = {SBOX_TABLE[x[31:24]], SBOX_TABLE[x[23:16]],
                SBOX_TABLE[x[15:8]], SBOX_TABLE[x[7:0]]};
  endfunction

  // Linear transform of the data rounds: B ^ rotl2 ^ rotl10 ^ rotl18 ^ rotl24.
  function automatic logic [WORD_W-1:0] lin_data(input logic [WORD_W-1:0] b);
    lin_data = b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]}
                 ^ {b[13:0], b[31:14]} ^ {b[7:0], b[31:8]};
  endfunction

  // Linear transform of the key schedule: B ^ rotl13 ^ rotl23.
  function automatic logic [WORD_W-1:0] lin_key(input logic [WORD_W-1:0] b);
    lin_key = b ^ {b[18:0], b[31:19]} ^ {b[8:0], b[31:9]};
  endfunction

endpackage

// ----- hdl/sm4c_ctrl.sv -----
// Controller state machine: key expansion, round sequencing and result handoff.
`timescale 1ns / 1ps
module sm4c_ctrl
  import sm4c_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  sm4c_status_t status,
  output sm4c_cmd_t    cmd
);

  sm4c_state_t       state_r, state_nxt;
  logic [RIDX_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    in_tready     = 1'b0;
    cmd           = '0;
    cmd.round_idx = cnt_r;

    case (state_r)
      ST_IDLE: begin
        in_tready = !cfg_we;
        if (in_tvalid && !cfg_we) begin
          cmd.load_data = 1'b1;
          cnt_nxt       = '0;
          state_nxt     = ST_ROUND;
        end
      end
      ST_KLOAD: begin
        cmd.load_key = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = ST_KEY;
      end
      ST_KEY: begin
        cmd.round_en = 1'b1;
        cmd.key_mode = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == ROUND_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_ROUND: begin
        cmd.round_en = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == ROUND_LAST) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // Hold the finished block until the output register is free.
        if (!status.out_busy) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // A key write restarts the schedule from the updated key registers.
    if (cfg_we) begin
      state_nxt = ST_KLOAD;
    end
  end

endmodule

// ----- hdl/sm4c_datapath.sv -----
// Datapath: key and chaining registers, shared round unit, round keys, output register.
`timescale 1ns / 1ps
module sm4c_datapath
  import sm4c_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  sm4c_cmd_t             cmd,
  output sm4c_status_t          status,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic [HALF_W-1:0]     block_high,
  input  logic [HALF_W-1:0]     block_low,
  input  logic [VB_W-1:0]       valid_bytes,
  input  logic                  first_block,
  output logic [HALF_W-1:0]     cipher_high,
  output logic [HALF_W-1:0]     cipher_low,
  output logic                  out_tvalid,
  input  logic                  out_tready
);

  logic [HALF_W-1:0]  key_high_r, key_low_r;
  logic [HALF_W-1:0]  chain_high_r, chain_low_r;
  logic [HALF_W-1:0]  out_high_r, out_low_r;
  logic               out_valid_r;
  logic [WORD_W-1:0]  w_r [4];
  logic [WORD_W-1:0]  rk_mem [NUM_ROUNDS];

  logic [VB_W-1:0]    vb_sat;
  logic [BLOCK_W-1:0] padded;
  logic [BLOCK_W-1:0] chain_in;
  logic [BLOCK_W-1:0] whitened;
  logic [WORD_W-1:0]  rk_word;
  logic [WORD_W-1:0]  mix_word;
  logic [WORD_W-1:0]  sub_out;
  logic [WORD_W-1:0]  lin_out;
  logic [WORD_W-1:0]  new_word;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_KEY_HIGH: key_high_r <= cfg_wdata;
        REG_KEY_LOW:  key_low_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Replace every byte at or beyond the valid count by the pad byte.
  always_comb begin
    vb_sat = (valid_bytes > FULL_BYTES) ? FULL_BYTES : valid_bytes;
    padded = {block_high, block_low};
    for (int i = 0; i < NUM_BYTES; i++) begin
      if (VB_W'(i) >= vb_sat) begin
        padded[BLOCK_W-1-8*i -: 8] = PAD_BYTE;
      end
    end
    chain_in = first_block ? '0 : {chain_high_r, chain_low_r};
    whitened = padded ^ chain_in;
  end

  // One round of either the key schedule or the cipher.
  always_comb begin
    rk_word  = cmd.key_mode ? CK_TABLE[cmd.round_idx] : rk_mem[cmd.round_idx];
    mix_word = w_r[1] ^ w_r[2] ^ w_r[3] ^ rk_word;
    sub_out  = sub_word(mix_word);
    lin_out  = cmd.key_mode ? lin_key(sub_out) : lin_data(sub_out);
    new_word = w_r[0] ^ lin_out;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_key) begin
      w_r[0] <= key_high_r[63:32] ^ FK0;
      w_r[1] <= key_high_r[31:0]  ^ FK1;
      w_r[2] <= key_low_r[63:32]  ^ FK2;
      w_r[3] <= key_low_r[31:0]   ^ FK3;
    end else if (cmd.load_data) begin
      w_r[0] <= whitened[127:96];
      w_r[1] <= whitened[95:64];
      w_r[2] <= whitened[63:32];
      w_r[3] <= whitened[31:0];
    end else if (cmd.round_en) begin
      w_r[0] <= w_r[1];
      w_r[1] <= w_r[2];
      w_r[2] <= w_r[3];
      w_r[3] <= new_word;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.round_en && cmd.key_mode) begin
      rk_mem[cmd.round_idx] <= new_word;
    end
  end

  // Ciphertext is the final state in reverse word order.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_high_r <= '0;
      chain_low_r  <= '0;
    end else if (cmd.finish) begin
      chain_high_r <= {w_r[3], w_r[2]};
      chain_low_r  <= {w_r[1], w_r[0]};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_high_r <= {w_r[3], w_r[2]};
      out_low_r  <= {w_r[1], w_r[0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign status.out_busy = out_valid_r && !out_tready;
  assign out_tvalid      = out_valid_r;
  assign cipher_high     = out_high_r;
  assign cipher_low      = out_low_r;

endmodule

// ----- hdl/sm4_cbc_encryptor.sv -----
// SM4 encryption in CBC mode, top level: stream ports, key port, controller and datapath.
//
// Encrypts 128-bit blocks with the SM4 cipher in CBC mode. Write the key with two
// register writes: index 0 takes key bytes 0..7, index 1 takes key bytes 8..15,
// both big-endian. Every key write starts the key schedule over from the current
// key registers; it runs a load step, then 32 rounds, after the last key
// write, and in_tready stays low meanwhile. Do not send data before the first key
// write. Each input transaction carries a plaintext block, a count of leading valid
// bytes (the rest are replaced by 0x20; zero pads all sixteen, counts above sixteen
// mean sixteen) and, in tuser, a first-block flag that restarts the chain from zero.
// A block passes through the core in order: the acceptance cycle pads and XORs it with
// the chaining value into the round state, 32 rounds run through the single shared
// round unit (S-box, linear transform, round-key fetch), and a write-back step
// loads the output register once it is free, which raises out_tvalid.
// The next block is accepted in the cycle after write-back, even while the previous
// ciphertext still waits in the output register; the write-back of a later block
// holds until that register is free.
`timescale 1ns / 1ps
module sm4_cbc_encryptor
  import sm4c_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Key register write port
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // Plaintext stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // block_high[63:0], block_low[127:64],
                                            // valid_bytes[132:128], zero fill [135:133]
  input  logic                  in_tuser,   // first_block
  // Ciphertext stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // cipher_high[63:0], cipher_low[127:64]
);

  sm4c_cmd_t         cmd;
  sm4c_status_t      status;
  logic [HALF_W-1:0] cipher_high;
  logic [HALF_W-1:0] cipher_low;

  // Sequence key expansion and block encryption.
  sm4c_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  // Hold keys, chain value, round state and the output register.
  sm4c_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .status      (status),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .block_high  (in_tdata[63:0]),
    .block_low   (in_tdata[127:64]),
    .valid_bytes (in_tdata[132:128]),
    .first_block (in_tuser),
    .cipher_high (cipher_high),
    .cipher_low  (cipher_low),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready)
  );

  assign out_tdata = {cipher_low, cipher_high};

endmodule

// ----- hdl/sm4c_checker.sv -----
// Port-level checker for the SM4 CBC encryptor, bound to the top level.
`timescale 1ns / 1ps
module sm4c_checker
  import sm4c_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  cfg_we,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  // A stalled result holds its value.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed or dropped while stalled");

  // One block at a time: busy right after a transaction is accepted.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second block accepted while one is being encrypted");

  // A key write starts the schedule, which holds off input.
  assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_tready)
    else $error("input accepted during key expansion");

  // A result cannot appear in the cycle after a block is taken.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !$rose(out_tvalid))
    else $error("result appeared without running the rounds");

endmodule

bind sm4_cbc_encryptor sm4c_checker u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .cfg_we     (cfg_we),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ----- tb/sv/sm4_chain_checker.sv -----
// Scoreboard for the SM4 CBC encryptor: tracks key writes, predicts ciphertext, checks results.
`timescale 1ns / 1ps
module sm4_chain_checker
  import sm4c_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // block_high, block_low, valid_bytes, zero fill
  input  logic                  in_tuser,   // first_block
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,  // cipher_high, cipher_low
  output int                    mismatch_count,
  output int                    cipher_pending
);

  typedef struct packed {
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
  } cipher_t;

  localparam logic [7:0] PAD_FILL = 8'h20;

  localparam logic [7:0] SUBST [256] = '{
  8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
  8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
  8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
  8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
  8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
  8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
  8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
  8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
  8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
  8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
  8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
  8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
  8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
  8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
  8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
  8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  localparam logic [31:0] FK_WORD [4] = '{32'ha3b1bac6, 32'h56aa3350, 32'h677d9197, 32'hb27022dc};

  logic [63:0] key_hi_q, key_lo_q;
  logic [63:0] chain_hi_q, chain_lo_q;
  logic [31:0] rkey [32];
  cipher_t     cipher_due_q [$];

  function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
    rotl = (v << n) | (v >> (32 - n));
  endfunction

  function automatic logic [31:0] tau(input logic [31:0] a);
    tau = {SUBST[a[31:24]], SUBST[a[23:16]], SUBST[a[15:8]], SUBST[a[7:0]]};
  endfunction

  function automatic logic [31:0] data_mix(input logic [31:0] b);
    data_mix = b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
  endfunction

  function automatic logic [31:0] key_mix(input logic [31:0] b);
    key_mix = b ^ rotl(b, 13) ^ rotl(b, 23);
  endfunction

  // CK byte j of round r is (4r + j) * 7 mod 256, most significant byte first.
  function automatic logic [31:0] ck_word(input int r);
    logic [31:0] w;
    int j;
    w = '0;
    for (j = 0; j < 4; j++) w = {w[23:0], 8'(((4 * r + j) * 7) % 256)};
    return w;
  endfunction

  // Rebuild all 32 round keys from the current key registers.
  function automatic void expand_schedule();
    logic [31:0] k [4];
    logic [31:0] nk;
    int i;
    k[0] = key_hi_q[63:32] ^ FK_WORD[0];
    k[1] = key_hi_q[31:0]  ^ FK_WORD[1];
    k[2] = key_lo_q[63:32] ^ FK_WORD[2];
    k[3] = key_lo_q[31:0]  ^ FK_WORD[3];
    for (i = 0; i < 32; i++) begin
      nk = k[0] ^ key_mix(tau(k[1] ^ k[2] ^ k[3] ^ ck_word(i)));
      rkey[i] = nk;
      k[0] = k[1];
      k[1] = k[2];
      k[2] = k[3];
      k[3] = nk;
    end
  endfunction

  // Pad, chain and encrypt one block; advances the chaining value.
  function automatic cipher_t sm4_cbc_cipher(input logic [127:0] plain, input logic [4:0] vb,
                                             input logic first);
    logic [127:0] blk;
    logic [31:0]  x [4];
    logic [31:0]  nx;
    int           cnt;
    int           i;
    cipher_t      res;
    cnt = (vb > 16) ? 16 : int'(vb);
    blk = plain;
    for (i = cnt; i < 16; i++) blk[127 - 8 * i -: 8] = PAD_FILL;
    if (first) begin
      chain_hi_q = '0;
      chain_lo_q = '0;
    end
    blk ^= {chain_hi_q, chain_lo_q};
    x[0] = blk[127:96];
    x[1] = blk[95:64];
    x[2] = blk[63:32];
    x[3] = blk[31:0];
    for (i = 0; i < 32; i++) begin
      nx = x[0] ^ data_mix(tau(x[1] ^ x[2] ^ x[3] ^ rkey[i]));
      x[0] = x[1];
      x[1] = x[2];
      x[2] = x[3];
      x[3] = nx;
    end
    res.cipher_high = {x[3], x[2]};
    res.cipher_low  = {x[1], x[0]};
    chain_hi_q = res.cipher_high;
    chain_lo_q = res.cipher_low;
    return res;
  endfunction

  always @(posedge clk) begin
    cipher_t want;
    if (!rst_n) begin
      key_hi_q = '0;
      key_lo_q = '0;
      chain_hi_q = '0;
      chain_lo_q = '0;
      for (int i = 0; i < 32; i++) rkey[i] = '0;
      cipher_due_q.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_addr == REG_KEY_HIGH) begin
          key_hi_q = cfg_wdata;
          expand_schedule();
        end else if (cfg_addr == REG_KEY_LOW) begin
          key_lo_q = cfg_wdata;
          expand_schedule();
        end
      end
      if (in_tvalid && in_tready)
        cipher_due_q.push_back(sm4_cbc_cipher({in_tdata[63:0], in_tdata[127:64]},
                                              in_tdata[132:128], in_tuser));
      if (out_tvalid && out_tready) begin
        if (cipher_due_q.size() == 0) begin
          $display("%0t: ciphertext with no block outstanding: expected none, got %h",
                   $time, out_tdata);
          mismatch_count++;
        end else begin
          want = cipher_due_q.pop_front();
          if (out_tdata[63:0] !== want.cipher_high) begin
            $display("%0t: cipher_high expected %h, got %h", $time, want.cipher_high,
                     out_tdata[63:0]);
            mismatch_count++;
          end
          if (out_tdata[127:64] !== want.cipher_low) begin
            $display("%0t: cipher_low expected %h, got %h", $time, want.cipher_low,
                     out_tdata[127:64]);
            mismatch_count++;
          end
        end
      end
    end
    cipher_pending = cipher_due_q.size();
  end

endmodule

// ----- tb/sv/testbench.sv -----
// Top of the SM4 CBC encryptor testbench: clock, reset, key writes, block stimulus, verdict.
`timescale 1ns / 1ps
module testbench;
  import sm4c_pkg::*;

  // Pause after the last ciphertext before touching the key port or ending the run;
  // it is longer than a block's pass through the core, so this covers any straggler.
  localparam int DRAIN_CYCLES   = 40;
  // Cycles without any transaction before the run is declared hung. The slowest
  // legal gap is a key schedule, a block, a receiver stall and a sender gap, plus
  // the drain pause: well below this.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 75;

  localparam logic [127:0] STD_KEY   = 128'h0123456789abcdef_fedcba9876543210;
  localparam logic [127:0] STD_PLAIN = 128'h0123456789abcdef_fedcba9876543210;

  typedef enum int {
    READY_ALWAYS,
    READY_MOSTLY,
    READY_SPARSE,
    READY_BLOCKED
  } ready_mode_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  int          mismatch_count;
  int          cipher_pending;
  int          burst_left  = 0;
  int          ready_left  = 0;
  int          idle_cycles = 0;
  int          items_sent  = 0;
  ready_mode_t ready_mode  = READY_ALWAYS;

  sm4_cbc_encryptor i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  sm4_chain_checker u_chain_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .mismatch_count (mismatch_count),
    .cipher_pending (cipher_pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver backpressure: pick a stall mode for a random stretch of cycles. The
  // blocked mode holds tready low for most of its stretch, so results pile up in the
  // output register and the core has to hold its write-back.
  always @(negedge clk) begin
    if (ready_left == 0) begin
      ready_mode = ready_mode_t'($urandom_range(0, 3));
      ready_left = $urandom_range(16, 96);
    end else begin
      ready_left--;
    end
    case (ready_mode)
      READY_ALWAYS:  out_tready <= 1'b1;
      READY_MOSTLY:  out_tready <= ($urandom_range(0, 3) != 0);
      READY_SPARSE:  out_tready <= ($urandom_range(0, 3) == 0);
      READY_BLOCKED: out_tready <= (ready_left < 4);
      default:       out_tready <= 1'b1;
    endcase
  end

  // Watchdog: any transaction on either stream or a key write restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Mostly random halves, with all-zero and all-one values mixed in.
  function automatic logic [63:0] rand_half();
    case ($urandom_range(0, 15))
      0:       rand_half = '0;
      1:       rand_half = '1;
      default: rand_half = {$urandom, $urandom};
    endcase
  endfunction

  // Offer one block and hold it until the transaction completes. Valid stays high
  // across back-to-back blocks of a burst; it drops for a gap between bursts and when draining.
  task automatic send_block(input logic [63:0] hi, input logic [63:0] lo,
                            input logic [4:0] vb, input logic first);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, vb, lo, hi};
    in_tuser  <= first;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  // Drop valid and wait until every outstanding ciphertext has come back,
  // then let the core settle.
  task automatic drain_all();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (cipher_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_key_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Key changes only while the core is idle.
  task automatic load_key(input logic [127:0] key, input bit do_high, input bit do_low);
    drain_all();
    if (do_high) write_key_reg(REG_KEY_HIGH, key[127:64]);
    if (do_low) write_key_reg(REG_KEY_LOW, key[63:0]);
  endtask

  // A well-formed message: first flag on block one, full middle blocks, a tail with
  // up to sixteen valid bytes. About one block in ten is noise with any count and a random flag.
  task automatic send_message(input int blocks);
    logic [4:0] vb;
    logic       first;
    for (int i = 0; i < blocks; i++) begin
      first = (i == 0);
      vb = (i == blocks - 1) ? 5'($urandom_range(0, 16)) : FULL_BYTES;
      if ($urandom_range(0, 9) == 0) begin
        vb    = 5'($urandom_range(0, 31));
        first = 1'($urandom_range(0, 1));
      end
      send_block(rand_half(), rand_half(), vb, first);
    end
  endtask

  initial begin
    int           phase_start;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part under the standard test key: the standard vector, chaining,
    // extreme data, every padding boundary, oversized counts and a restart mid-stream.
    load_key(STD_KEY, 1'b1, 1'b1);
    send_block(STD_PLAIN[127:64], STD_PLAIN[63:0], FULL_BYTES, 1'b1);
    send_block(STD_PLAIN[127:64], STD_PLAIN[63:0], FULL_BYTES, 1'b0);
    send_block('0, '0, FULL_BYTES, 1'b1);
    send_block('1, '1, FULL_BYTES, 1'b0);
    send_block('1, '1, 5'd0, 1'b0);
    send_block('1, '1, 5'd1, 1'b0);
    send_block('1, '1, 5'd7, 1'b0);
    send_block('1, '1, 5'd8, 1'b0);
    send_block('1, '1, 5'd9, 1'b0);
    send_block('1, '1, 5'd15, 1'b0);
    send_block(rand_half(), rand_half(), 5'd17, 1'b0);
    send_block('1, '1, 5'd31, 1'b0);
    send_block('0, '0, 5'd0, 1'b1);
    send_block(rand_half(), rand_half(), 5'd16, 1'b1);
    send_block(rand_half(), rand_half(), 5'd3, 1'b0);
    // Hold off until the pipeline is empty before moving on to the random phases.
    drain_all();

    // Random phases: extreme keys first, then random keys, some rewriting only one
    // half so the schedule is rebuilt from a mix of old and new key bytes.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       load_key('1, 1'b1, 1'b1);
        1:       load_key('0, 1'b1, 1'b1);
        3:       load_key({$urandom, $urandom, $urandom, $urandom}, 1'b1, 1'b0);
        4:       load_key({$urandom, $urandom, $urandom, $urandom}, 1'b0, 1'b1);
        default: load_key({$urandom, $urandom, $urandom, $urandom}, 1'b1, 1'b1);
      endcase
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        send_message($urandom_range(1, 12));
        if ($urandom_range(0, 15) == 0) drain_all();
      end
    end

    drain_all();
    if (mismatch_count == 0 && cipher_pending == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
